@@ hw/rtl/tfpc_pkg.sv @@
`default_nettype none

package tfpc_pkg;

	localparam int RAW_W        = 12;
	localparam int CORNERS      = 4;
	localparam int CORNER_W     = 3;
	localparam int PROD_W       = 25;
	localparam int MAG_W        = 24;
	localparam int S_DATA_W     = 32;
	localparam int S_USER_W     = 2;
	localparam int M_DATA_W     = 32;
	localparam int SCREEN_W_DEF = 320;
	localparam int SCREEN_H_DEF = 240;

	typedef enum logic [1:0] {
		CMD_XFORM = 2'd0,
		CMD_START = 2'd1,
		CMD_POLL  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic start_mul;
		logic start_div;
		logic commit;
		logic emit_xform;
	} ctrl_cmd_t;

	typedef struct packed {
		logic calc;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/tfpc_div.sv @@
`default_nettype none

module tfpc_div
	import tfpc_pkg::*;
#(
	parameter int N_W = MAG_W,
	parameter int D_W = RAW_W
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [N_W-1:0] dividend,
	input  wire logic [D_W-1:0] divisor,
	output logic                busy,
	output logic [N_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [D_W:0]     rem_sh;
	logic [D_W:0]     rem_nx;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[N_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? rem_sh - {1'b0, div_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/tfpc_ctrl.sv @@
`default_nettype none

module tfpc_ctrl
	import tfpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.calc) state_nx = ST_MUL;
				else if (status.out_free) state_nx = ST_IDLE;
			end
			ST_MUL: state_nx = ST_DIV;
			ST_DIV: begin
				if (status.div_done) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_EXEC: begin
				cmd.start_mul = status.calc;
				cmd.commit    = !status.calc && status.out_free;
			end
			ST_MUL: cmd.start_div = 1'b1;
			ST_DIV: ;
			ST_OUT: cmd.emit_xform = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/tfpc_datapath.sv @@
`default_nettype none

module tfpc_datapath
	import tfpc_pkg::*;
#(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           cmd,
	output dp_status_t               status,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire logic [S_USER_W-1:0] s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata
);

	localparam logic [RAW_W-1:0] SIZE_X = RAW_W'(SCREEN_W);
	localparam logic [RAW_W-1:0] SIZE_Y = RAW_W'(SCREEN_H);

	typedef struct packed {
		logic [RAW_W-1:0] val;
		logic             clamp;
		logic             err;
	} axis_t;

	function automatic axis_t axis_fix(input logic [MAG_W-1:0] q, input logic neg,
			input logic zero, input logic [RAW_W-1:0] size);
		axis_t r;
		r = '0;
		priority if (zero) begin
			r.err = 1'b1;
		end else if (neg) begin
			r.clamp = q != '0;
		end else if (q >= MAG_W'(size)) begin
			r.val   = size - RAW_W'(1);
			r.clamp = 1'b1;
		end else begin
			r.val = q[RAW_W-1:0];
		end
		return r;
	endfunction

	cmd_t             cmd_q;
	logic [RAW_W-1:0] sx_q, sy_q;
	logic             pr_q, cc_q;

	logic [RAW_W-1:0]    left_q, right_q, top_q, bottom_q;
	logic                ok_q;
	logic [CORNER_W-1:0] corner_q;
	logic                rw_q, prev_q;
	logic [2*RAW_W-1:0]  samp_q [CORNERS];

	logic [RAW_W-1:0]    left_nx, right_nx, top_nx, bottom_nx;
	logic                ok_nx, rw_nx, prev_nx, done_nx, capture;
	logic [CORNER_W-1:0] corner_nx, corner_inc;
	logic [RAW_W:0]      sum_l, sum_r, sum_t, sum_b;

	logic signed [RAW_W:0]    diff_x, diff_y, span_x, span_y;
	logic signed [PROD_W:0]   prod_xf, prod_yf;
	logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
	logic signed [RAW_W:0]    span_x_q, span_y_q;
	logic [PROD_W-1:0]        mag_x, mag_y;
	logic [RAW_W:0]           smag_x, smag_y;
	logic [MAG_W-1:0]         q_x, q_y;
	logic                     busy_x, busy_y;
	axis_t                    ax_x, ax_y;

	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_q;
	logic [RAW_W-1:0]    ox, oy;
	logic                oclamp, oerr;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= cmd_t'(s_tuser[1:0]);
			sx_q  <= s_tdata[RAW_W-1:0];
			sy_q  <= s_tdata[2*RAW_W-1:RAW_W];
			pr_q  <= s_tdata[2*RAW_W];
			cc_q  <= s_tdata[2*RAW_W+1];
		end
	end

	// calibration state update
	assign corner_inc = corner_q + CORNER_W'(1);
	assign sum_l = {1'b0, samp_q[0][RAW_W-1:0]} + {1'b0, samp_q[3][RAW_W-1:0]};
	assign sum_r = {1'b0, samp_q[1][RAW_W-1:0]} + {1'b0, samp_q[2][RAW_W-1:0]};
	assign sum_t = {1'b0, samp_q[0][2*RAW_W-1:RAW_W]} + {1'b0, samp_q[1][2*RAW_W-1:RAW_W]};
	assign sum_b = {1'b0, samp_q[2][2*RAW_W-1:RAW_W]} + {1'b0, samp_q[3][2*RAW_W-1:RAW_W]};

	always_comb begin
		left_nx   = left_q;
		right_nx  = right_q;
		top_nx    = top_q;
		bottom_nx = bottom_q;
		ok_nx     = ok_q;
		corner_nx = corner_q;
		rw_nx     = rw_q;
		prev_nx   = prev_q;
		done_nx   = 1'b0;
		capture   = 1'b0;
		unique case (cmd_q)
			CMD_XFORM: ;
			CMD_START: begin
				ok_nx     = 1'b0;
				corner_nx = '0;
				rw_nx     = 1'b0;
				prev_nx   = 1'b0;
			end
			CMD_POLL: begin
				if (!corner_q[CORNER_W-1]) begin
					priority if (rw_q) begin
						if (!pr_q) begin
							rw_nx     = 1'b0;
							corner_nx = corner_inc;
							if (corner_inc == CORNER_W'(CORNERS)) begin
								left_nx   = sum_l[RAW_W:1];
								right_nx  = sum_r[RAW_W:1];
								top_nx    = sum_t[RAW_W:1];
								bottom_nx = sum_b[RAW_W:1];
								ok_nx     = 1'b1;
								done_nx   = 1'b1;
							end
						end
					end else if (pr_q && cc_q && !prev_q) begin
						capture = 1'b1;
						rw_nx   = 1'b1;
					end else begin
					end
					prev_nx = pr_q;
				end
			end
			CMD_CLEAR: ok_nx = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			ok_q     <= 1'b0;
			corner_q <= CORNER_W'(CORNERS);
			rw_q     <= 1'b0;
			prev_q   <= 1'b0;
		end else if (cmd.commit) begin
			left_q   <= left_nx;
			right_q  <= right_nx;
			top_q    <= top_nx;
			bottom_q <= bottom_nx;
			ok_q     <= ok_nx;
			corner_q <= corner_nx;
			rw_q     <= rw_nx;
			prev_q   <= prev_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && capture) begin
			samp_q[corner_q[1:0]] <= {sy_q, sx_q};
		end
	end

	// transform: product, then one divider per axis on magnitudes
	assign diff_x  = $signed({1'b0, sx_q}) - $signed({1'b0, left_q});
	assign diff_y  = $signed({1'b0, sy_q}) - $signed({1'b0, top_q});
	assign span_x  = $signed({1'b0, right_q}) - $signed({1'b0, left_q});
	assign span_y  = $signed({1'b0, bottom_q}) - $signed({1'b0, top_q});
	assign prod_xf = diff_x * $signed({1'b0, SIZE_X});
	assign prod_yf = diff_y * $signed({1'b0, SIZE_Y});

	always_ff @(posedge clk) begin
		if (cmd.start_mul) begin
			prod_x_q <= prod_xf[PROD_W-1:0];
			prod_y_q <= prod_yf[PROD_W-1:0];
			span_x_q <= span_x;
			span_y_q <= span_y;
		end
	end

	assign mag_x  = prod_x_q[PROD_W-1] ? PROD_W'(-prod_x_q) : PROD_W'(prod_x_q);
	assign mag_y  = prod_y_q[PROD_W-1] ? PROD_W'(-prod_y_q) : PROD_W'(prod_y_q);
	assign smag_x = span_x_q[RAW_W] ? (RAW_W+1)'(-span_x_q) : (RAW_W+1)'(span_x_q);
	assign smag_y = span_y_q[RAW_W] ? (RAW_W+1)'(-span_y_q) : (RAW_W+1)'(span_y_q);

	tfpc_div #(.N_W(MAG_W), .D_W(RAW_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (mag_x[MAG_W-1:0]),
		.divisor  (smag_x[RAW_W-1:0]),
		.busy     (busy_x),
		.quotient (q_x)
	);

	tfpc_div #(.N_W(MAG_W), .D_W(RAW_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (mag_y[MAG_W-1:0]),
		.divisor  (smag_y[RAW_W-1:0]),
		.busy     (busy_y),
		.quotient (q_y)
	);

	assign ax_x = axis_fix(q_x, prod_x_q[PROD_W-1] ^ span_x_q[RAW_W], span_x_q == '0, SIZE_X);
	assign ax_y = axis_fix(q_y, prod_y_q[PROD_W-1] ^ span_y_q[RAW_W], span_y_q == '0, SIZE_Y);

	// result register
	always_comb begin
		ox     = '0;
		oy     = '0;
		oclamp = 1'b0;
		oerr   = 1'b0;
		if (cmd.emit_xform) begin
			ox     = ax_x.val;
			oy     = ax_y.val;
			oclamp = ax_x.clamp | ax_y.clamp;
			oerr   = ax_x.err | ax_y.err;
		end else if (cmd_q == CMD_XFORM) begin
			ox = sx_q;
			oy = sy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.emit_xform) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit || cmd.emit_xform) begin
			out_q <= {done_nx, rw_nx, corner_nx, ok_nx, oerr, oclamp, oy, ox};
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_q;
	assign status.calc     = (cmd_q == CMD_XFORM) && ok_q;
	assign status.div_done = !busy_x && !busy_y;
	assign status.out_free = !out_valid_q || m_tready;

endmodule

`default_nettype wire

@@ hw/rtl/touch_four_point_calibrator_top.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: sample_x, sample_y, pressed, contact_count
//                                   tuser: command
// m_*       out  m_tvalid/m_tready  tdata: screen_x, screen_y, was_clamped, span_error,
//                                   bounds_valid, corner_index, awaiting_release,
//                                   calibration_done
//
// One item at a time. Calibration commands and transforms without valid bounds
// give their result from the execute state into the output register. A transform
// with valid bounds passes the per-axis product register, 24 steps of the
// radix-2 dividers, one per axis, and the output state before its result is given.
// Reset clears the bounds, the valid flag and the run state; corner index reads 4.
// While a result waits, the next item is taken and holds until the register frees.
`default_nettype none

module touch_four_point_calibrator_top
	import tfpc_pkg::*;
#(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// [11:0] sample_x, [23:12] sample_y, [24] pressed, [25] contact_count
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// [1:0] command
	input  wire logic [S_USER_W-1:0] s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [11:0] screen_x, [23:12] screen_y, [24] was_clamped, [25] span_error,
	// [26] bounds_valid, [29:27] corner_index, [30] awaiting_release,
	// [31] calibration_done
	output logic [M_DATA_W-1:0]      m_tdata
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	tfpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tfpc_datapath #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_done_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31] |-> m_tdata[26] && m_tdata[29:27] == 3'd4)
		else $error("calibration done without valid bounds or idle corner");

	a_release_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30] |-> !m_tdata[29])
		else $error("release wait outside a calibration run");

	a_flags_need_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[24] || m_tdata[25]) |-> m_tdata[26])
		else $error("clamp or span flag without valid bounds");

	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:27] <= 3'd4)
		else $error("corner index out of range");

endmodule

`default_nettype wire
